// ===== rtl/core/light_map_splat_accumulator_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef LIGHT_MAP_SPLAT_ACCUMULATOR_UNIT_ASSERT_SVH
`define LIGHT_MAP_SPLAT_ACCUMULATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define LMSA_ASSERT_NOW(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LMSA_ASSERT_NEXT(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lmsa_pkg.sv =====
package lmsa_pkg;

	localparam int DEF_MAP_COLS = 128;
	localparam int DEF_MAP_ROWS = 128;

	localparam int WIN_W     = 11;
	localparam int BRIGHT_W  = 9;
	localparam int DX_W      = 18;
	localparam int D2_W      = 33;
	localparam int RADC_W    = 58;
	localparam int ROOT_W    = 29;
	localparam int REM_W     = 31;
	localparam int QUO_W     = 12;
	localparam int ATT_W     = 13;
	localparam int A2_W      = 25;
	localparam int K_W       = 37;
	localparam int P_W       = 45;
	localparam int FULL_W    = 40;
	localparam int APROD_W   = 49;
	localparam int RADIUS_W  = 12;
	localparam int STEP_W    = 5;

	localparam logic [FULL_W-1:0] FULL_ALPHA = 40'hFF_0000_0000;
	localparam logic [ATT_W-1:0]  ONE_Q12    = 13'd4096;
	localparam logic [WIN_W-1:0]  WIDTH_RST  = 11'd1280;
	localparam logic [WIN_W-1:0]  HEIGHT_RST = 11'd720;

	typedef enum logic [1:0] {
		ACT_FILL  = 2'd0,
		ACT_SPLAT = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CFG_WINDOW_WIDTH       = 2'd0,
		CFG_WINDOW_HEIGHT      = 2'd1,
		CFG_AMBIENT_BRIGHTNESS = 2'd2,
		CFG_AMBIENT_COLOR      = 2'd3
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_CELL,
		ST_SQUARE,
		ST_ROOT,
		ST_DIV_INIT,
		ST_DIVIDE,
		ST_MUL_A,
		ST_MUL_K,
		ST_MUL_CH,
		ST_ALPHA,
		ST_SCALE,
		ST_WRITE,
		ST_READ
	} state_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_CLEAR,
		OP_LOAD,
		OP_START,
		OP_CELL,
		OP_SQUARE,
		OP_ROOT,
		OP_DIV_INIT,
		OP_DIVIDE,
		OP_MUL_A,
		OP_MUL_K,
		OP_MUL_CH,
		OP_ALPHA,
		OP_SCALE,
		OP_WRITE,
		OP_READ
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic skip;
		logic step_last;
		logic cell_last;
	} dp_status_t;

endpackage

// ===== rtl/core/lmsa_ram.sv =====
module lmsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/lmsa_ctrl.sv =====
module lmsa_ctrl import lmsa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					case (action_t'(action))
						ACT_READ:  state_d = ST_READ;
						ACT_FILL:  state_d = ST_CHECK;
						ACT_SPLAT: state_d = ST_CHECK;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_CHECK:    state_d = status.skip ? ST_IDLE : ST_CELL;
			ST_CELL:     state_d = ST_SQUARE;
			ST_SQUARE:   state_d = ST_ROOT;
			ST_ROOT: begin
				if (status.step_last) state_d = ST_DIV_INIT;
			end
			ST_DIV_INIT: state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (status.step_last) state_d = ST_MUL_A;
			end
			ST_MUL_A:    state_d = ST_MUL_K;
			ST_MUL_K:    state_d = ST_MUL_CH;
			ST_MUL_CH:   state_d = ST_ALPHA;
			ST_ALPHA:    state_d = ST_SCALE;
			ST_SCALE:    state_d = ST_WRITE;
			ST_WRITE:    state_d = status.cell_last ? ST_IDLE : ST_CELL;
			ST_READ:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_IDLE;
		case (state_q)
			ST_CLEAR:    cmd.op = OP_CLEAR;
			ST_IDLE:     cmd.op = start ? OP_LOAD : OP_IDLE;
			ST_CHECK:    cmd.op = status.skip ? OP_IDLE : OP_START;
			ST_CELL:     cmd.op = OP_CELL;
			ST_SQUARE:   cmd.op = OP_SQUARE;
			ST_ROOT:     cmd.op = OP_ROOT;
			ST_DIV_INIT: cmd.op = OP_DIV_INIT;
			ST_DIVIDE:   cmd.op = OP_DIVIDE;
			ST_MUL_A:    cmd.op = OP_MUL_A;
			ST_MUL_K:    cmd.op = OP_MUL_K;
			ST_MUL_CH:   cmd.op = OP_MUL_CH;
			ST_ALPHA:    cmd.op = OP_ALPHA;
			ST_SCALE:    cmd.op = OP_SCALE;
			ST_WRITE:    cmd.op = OP_WRITE;
			ST_READ:     cmd.op = OP_READ;
			default:     cmd.op = OP_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/lmsa_datapath.sv =====
module lmsa_datapath import lmsa_pkg::*; #(
	parameter int MAP_COLS = DEF_MAP_COLS,
	parameter int MAP_ROWS = DEF_MAP_ROWS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [1:0]         action,
	input  logic signed [15:0] light_x,
	input  logic signed [15:0] light_y,
	input  logic [11:0]        light_radius,
	input  logic [11:0]        light_brightness,
	input  logic [7:0]         light_red,
	input  logic [7:0]         light_green,
	input  logic [7:0]         light_blue,
	input  logic [7:0]         light_alpha,
	input  logic [6:0]         read_x,
	input  logic [6:0]         read_y,
	output logic [7:0]         cell_red,
	output logic [7:0]         cell_green,
	output logic [7:0]         cell_blue,
	output logic [7:0]         cell_alpha,
	output logic               done
);

	localparam int DEPTH = MAP_COLS * MAP_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAP_COLS);
	localparam int YW    = $clog2(MAP_ROWS);
	localparam int LINW  = AW + 7;

	function automatic logic [7:0] sat_add(input logic [7:0] cur, input logic [12:0] inc);
		logic [12:0] s;
		s = 13'(cur) + inc;
		return (s > 13'd255) ? 8'd255 : s[7:0];
	endfunction

	// configuration
	logic [WIN_W-1:0]    ww_q, wh_q;
	logic [BRIGHT_W-1:0] ab_q;
	logic [31:0]         ac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ww_q <= WIDTH_RST;
			wh_q <= HEIGHT_RST;
			ab_q <= '0;
			ac_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_WINDOW_WIDTH:       ww_q <= cfg_data[WIN_W-1:0];
				CFG_WINDOW_HEIGHT:      wh_q <= cfg_data[WIN_W-1:0];
				CFG_AMBIENT_BRIGHTNESS: ab_q <= cfg_data[BRIGHT_W-1:0];
				CFG_AMBIENT_COLOR:      ac_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// active area
	logic [WIN_W-1:0] cols_raw, rows_raw, cols, rows;
	assign cols_raw = {4'b0, ww_q[WIN_W-1:4]} + 11'd3;
	assign rows_raw = {4'b0, wh_q[WIN_W-1:4]} + 11'd3;
	assign cols = (cols_raw > WIN_W'(MAP_COLS)) ? WIN_W'(MAP_COLS) : cols_raw;
	assign rows = (rows_raw > WIN_W'(MAP_ROWS)) ? WIN_W'(MAP_ROWS) : rows_raw;

	// captured command
	logic                      fill_q, in_area_q;
	logic signed [15:0]        lx_q, ly_q;
	logic [RADIUS_W-1:0]       r_q;
	logic [11:0]               br_q;
	logic [7:0]                lr_q, lg_q, lb_q, la_q;

	// cell walk and arithmetic
	logic [XW-1:0]             x_q;
	logic [YW-1:0]             y_q;
	logic [AW-1:0]             addr_q, base_q, clr_q;
	logic [RADIUS_W-1:0]       rad_q;
	logic signed [DX_W-1:0]    dx_q, dy_q;
	logic [RADC_W-1:0]         radc_q;
	logic [REM_W-1:0]          rem_q;
	logic [ROOT_W-1:0]         root_q, div_rem_q;
	logic [22:0]               dsr_q;
	logic [QUO_W-1:0]          quo_q;
	logic                      over_q;
	logic [STEP_W-1:0]         step_q;
	logic [A2_W-1:0]           a2_q;
	logic [K_W-1:0]            k_q;
	logic [P_W-1:0]            pr_q, pg_q, pb_q, pa_q;
	logic [APROD_W-1:0]        aprod_q;
	logic [7:0]                red_q, green_q, blue_q, alpha_q;
	logic [7:0]                cell_red_q, cell_green_q, cell_blue_q, cell_alpha_q;
	logic                      done_q;

	logic [31:0]               rdata;

	// culling, in pixels
	logic signed [DX_W-1:0] lx_e, ly_e, r_e, ww_e, wh_e;
	logic                   cull;
	assign lx_e = DX_W'(lx_q);
	assign ly_e = DX_W'(ly_q);
	assign r_e  = signed'(DX_W'(r_q));
	assign ww_e = signed'(DX_W'(ww_q));
	assign wh_e = signed'(DX_W'(wh_q));
	assign cull = ((lx_e + r_e) < 18'sd0) || ((ly_e + r_e) < 18'sd0)
		|| ((lx_e - r_e) > ww_e) || ((ly_e - r_e) > wh_e);

	// offsets from the centre
	logic signed [DX_W-1:0] dx_fill, dy_fill, dx_splat, dy_splat;
	assign dx_fill  = signed'(DX_W'(x_q)) - signed'(DX_W'(cols >> 1));
	assign dy_fill  = signed'(DX_W'(y_q)) - signed'(DX_W'(rows >> 1));
	assign dx_splat = signed'(DX_W'({x_q, 4'b0})) - lx_e;
	assign dy_splat = signed'(DX_W'({y_q, 4'b0})) - ly_e;

	logic signed [2*DX_W-1:0] sqx, sqy;
	logic [D2_W-1:0]          d2;
	assign sqx = dx_q * dx_q;
	assign sqy = dy_q * dy_q;
	assign d2  = D2_W'(unsigned'(sqx)) + D2_W'(unsigned'(sqy));

	// one root digit per step
	logic [REM_W+1:0] rem2, trial;
	assign rem2  = {rem_q, radc_q[RADC_W-1 -: 2]};
	assign trial = (REM_W+2)'({root_q, 2'b01});

	logic [ATT_W-1:0] att;
	logic [A2_W-1:0]  a2_d;
	logic [11:0]      scale;
	logic [K_W-1:0]   k_d;
	logic [BRIGHT_W-1:0] inv;
	assign inv   = 9'd256 - ab_q;
	assign att   = over_q ? '0 : (ONE_Q12 - {1'b0, quo_q});
	assign a2_d  = att * att;
	assign scale = fill_q ? {3'b0, inv} : br_q;
	assign k_d   = a2_q * scale;

	logic [7:0] ch_r, ch_g, ch_b, ch_a;
	assign ch_r = fill_q ? ac_q[31:24] : lr_q;
	assign ch_g = fill_q ? ac_q[23:16] : lg_q;
	assign ch_b = fill_q ? ac_q[15:8]  : lb_q;
	assign ch_a = fill_q ? ac_q[7:0]   : la_q;

	logic [P_W-1:0] pr_d, pg_d, pb_d, pa_d;
	assign pr_d = k_q * ch_r;
	assign pg_d = k_q * ch_g;
	assign pb_d = k_q * ch_b;
	assign pa_d = k_q * ch_a;

	logic [FULL_W-1:0]  keep;
	logic [APROD_W-1:0] afill, asplat;
	assign keep   = (pa_q >= P_W'(FULL_ALPHA)) ? '0 : FULL_W'(P_W'(FULL_ALPHA) - pa_q);
	assign afill  = (FULL_ALPHA - FULL_W'(pa_q)) * inv;
	assign asplat = rdata[7:0] * keep;

	// divide by 255 with one correction
	logic [15:0] v255;
	logic [16:0] q0_sum, rem255;
	logic [7:0]  q0;
	assign v255   = aprod_q[47:32];
	assign q0_sum = 17'(v255) + 17'(v255[15:8]);
	assign q0     = q0_sum[15:8];
	assign rem255 = 17'(v255) - ({1'b0, q0, 8'b0} - 17'(q0));

	// cell reached at end of the walk
	logic x_last, y_last;
	assign x_last = (WIN_W'(x_q) == cols - 11'd1);
	assign y_last = (WIN_W'(y_q) == rows - 11'd1);

	// read address of a read command
	logic [LINW-1:0] rd_lin;
	assign rd_lin = LINW'(read_y) * LINW'(MAP_COLS) + LINW'(read_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= (cmd.op == OP_READ);
			case (cmd.op)
				OP_CLEAR:    clr_q <= clr_q + 1'b1;
				OP_SQUARE:   step_q <= STEP_W'(ROOT_W - 1);
				OP_DIV_INIT: step_q <= STEP_W'(QUO_W - 1);
				OP_ROOT:     step_q <= step_q - 1'b1;
				OP_DIVIDE:   step_q <= step_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				fill_q    <= (action_t'(action) == ACT_FILL);
				in_area_q <= (WIN_W'(read_x) < cols) && (WIN_W'(read_y) < rows);
				lx_q      <= light_x;
				ly_q      <= light_y;
				r_q       <= light_radius;
				br_q      <= light_brightness;
				lr_q      <= light_red;
				lg_q      <= light_green;
				lb_q      <= light_blue;
				la_q      <= light_alpha;
			end
			OP_START: begin
				x_q    <= '0;
				y_q    <= '0;
				addr_q <= '0;
				base_q <= '0;
				rad_q  <= fill_q ? RADIUS_W'(rows) : r_q;
			end
			OP_CELL: begin
				dx_q <= fill_q ? dx_fill : dx_splat;
				dy_q <= fill_q ? dy_fill : dy_splat;
			end
			OP_SQUARE: begin
				radc_q <= {1'b0, d2, 24'b0};
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_ROOT: begin
				radc_q <= radc_q << 2;
				if (rem2 >= trial) begin
					rem_q  <= REM_W'(rem2 - trial);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= REM_W'(rem2);
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			OP_DIV_INIT: begin
				over_q    <= (root_q >= ROOT_W'({rad_q, 12'b0}));
				div_rem_q <= root_q;
				dsr_q     <= {rad_q, 11'b0};
				quo_q     <= '0;
			end
			OP_DIVIDE: begin
				dsr_q <= dsr_q >> 1;
				if (div_rem_q >= ROOT_W'(dsr_q)) begin
					div_rem_q <= div_rem_q - ROOT_W'(dsr_q);
					quo_q     <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					quo_q     <= {quo_q[QUO_W-2:0], 1'b0};
				end
			end
			OP_MUL_A: a2_q <= a2_d;
			OP_MUL_K: k_q <= k_d;
			OP_MUL_CH: begin
				pr_q <= pr_d;
				pg_q <= pg_d;
				pb_q <= pb_d;
				pa_q <= pa_d;
			end
			OP_ALPHA: begin
				if (fill_q) begin
					aprod_q <= afill;
					red_q   <= pr_q[39:32];
					green_q <= pg_q[39:32];
					blue_q  <= pb_q[39:32];
				end else begin
					aprod_q <= asplat;
					red_q   <= sat_add(rdata[31:24], pr_q[44:32]);
					green_q <= sat_add(rdata[23:16], pg_q[44:32]);
					blue_q  <= sat_add(rdata[15:8], pb_q[44:32]);
				end
			end
			OP_SCALE: begin
				if (fill_q) begin
					alpha_q <= aprod_q[47:40];
				end else begin
					alpha_q <= q0 + ((rem255 >= 17'd255) ? 8'd1 : 8'd0);
				end
			end
			OP_WRITE: begin
				if (x_last) begin
					x_q    <= '0;
					y_q    <= y_q + 1'b1;
					base_q <= AW'(base_q + AW'(MAP_COLS));
					addr_q <= AW'(base_q + AW'(MAP_COLS));
				end else begin
					x_q    <= x_q + 1'b1;
					addr_q <= addr_q + 1'b1;
				end
			end
			OP_READ: begin
				cell_red_q   <= in_area_q ? rdata[31:24] : 8'd0;
				cell_green_q <= in_area_q ? rdata[23:16] : 8'd0;
				cell_blue_q  <= in_area_q ? rdata[15:8]  : 8'd0;
				cell_alpha_q <= in_area_q ? rdata[7:0]   : 8'd0;
			end
			default: ;
		endcase
	end

	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [31:0]     ram_wdata;
	assign ram_we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_WRITE);
	assign ram_waddr = (cmd.op == OP_CLEAR) ? clr_q : addr_q;
	assign ram_wdata = (cmd.op == OP_CLEAR) ? 32'd0 : {red_q, green_q, blue_q, alpha_q};
	assign ram_re    = (cmd.op == OP_LOAD) || (cmd.op == OP_CELL);
	assign ram_raddr = (cmd.op == OP_LOAD) ? AW'(rd_lin) : addr_q;

	lmsa_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	assign status.clear_last = (clr_q == AW'(DEPTH - 1));
	assign status.skip       = ab_q[8] || (!fill_q && ((r_q == '0) || cull));
	assign status.step_last  = (step_q == '0);
	assign status.cell_last  = x_last && y_last;

	assign cell_red   = cell_red_q;
	assign cell_green = cell_green_q;
	assign cell_blue  = cell_blue_q;
	assign cell_alpha = cell_alpha_q;
	assign done       = done_q;

endmodule

// ===== rtl/core/light_map_splat_accumulator_unit.sv =====
// RGBA light map of (window/16 + 3) cells per side, up to MAP_COLS x MAP_ROWS, kept in one
// single-port-write, registered-read RAM. After reset the block sweeps the RAM to zero, one
// cell a cycle, with busy high. A command is taken when start is high and busy low. A read
// returns its cell on cell_* with done high for one cycle, registered from the READ state that
// follows the command; done cannot be held off, so capture it then. Fill and splat give no
// result; each cell goes through one shared sequence of a 29-step square root, a 12-step
// division and the multiply steps before its write-back. An ignored or culled command writes
// no cell. Unknown actions are taken and dropped.
module light_map_splat_accumulator_unit import lmsa_pkg::*; #(
	parameter int MAP_COLS = DEF_MAP_COLS,
	parameter int MAP_ROWS = DEF_MAP_ROWS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [1:0]         action,
	input  logic signed [15:0] light_x,
	input  logic signed [15:0] light_y,
	input  logic [11:0]        light_radius,
	input  logic [11:0]        light_brightness,
	input  logic [7:0]         light_red,
	input  logic [7:0]         light_green,
	input  logic [7:0]         light_blue,
	input  logic [7:0]         light_alpha,
	input  logic [6:0]         read_x,
	input  logic [6:0]         read_y,
	output logic               done,
	output logic [7:0]         cell_red,
	output logic [7:0]         cell_green,
	output logic [7:0]         cell_blue,
	output logic [7:0]         cell_alpha
);

	dp_cmd_t    cmd;
	dp_status_t status;

	lmsa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.action(action),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	lmsa_datapath #(
		.MAP_COLS(MAP_COLS),
		.MAP_ROWS(MAP_ROWS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.action          (action),
		.light_x         (light_x),
		.light_y         (light_y),
		.light_radius    (light_radius),
		.light_brightness(light_brightness),
		.light_red       (light_red),
		.light_green     (light_green),
		.light_blue      (light_blue),
		.light_alpha     (light_alpha),
		.read_x          (read_x),
		.read_y          (read_y),
		.cell_red        (cell_red),
		.cell_green      (cell_green),
		.cell_blue       (cell_blue),
		.cell_alpha      (cell_alpha),
		.done            (done)
	);

endmodule

// ===== rtl/core/lmsa_checker.sv =====
`include "light_map_splat_accumulator_unit_assert.svh"

module lmsa_checker import lmsa_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               cfg_we,
	input logic [1:0]         cfg_index,
	input logic [31:0]        cfg_data,
	input logic [1:0]         action,
	input logic signed [15:0] light_x,
	input logic signed [15:0] light_y,
	input logic [11:0]        light_radius,
	input logic [11:0]        light_brightness,
	input logic [7:0]         light_red,
	input logic [7:0]         light_green,
	input logic [7:0]         light_blue,
	input logic [7:0]         light_alpha,
	input logic [6:0]         read_x,
	input logic [6:0]         read_y,
	input logic               done,
	input logic [7:0]         cell_red,
	input logic [7:0]         cell_green,
	input logic [7:0]         cell_blue,
	input logic [7:0]         cell_alpha
);

	// a result beat only follows a taken read command
	`LMSA_ASSERT_NOW(a_done_after_read, clk, arst_n, done, $past(start && !busy && action == ACT_READ, 2), "result without a read command")

	// a real command makes the block busy in the cycle after it is taken
	`LMSA_ASSERT_NEXT(a_cmd_busy, clk, arst_n, start && !busy && (action == ACT_FILL || action == ACT_SPLAT || action == ACT_READ), busy, "command taken without going busy")

	`LMSA_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "result beat longer than one cycle")

	// the read has finished by the time its beat shows
	`LMSA_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "result beat while still busy")

endmodule

bind light_map_splat_accumulator_unit lmsa_checker u_lmsa_checker (.*);
